FILE: rtl/bpfm_pkg.sv
package bpfm_pkg;

  localparam int unsigned FRAMES = 1024;
  localparam int unsigned SLOTS  = 2048;
  localparam int unsigned FRM_W  = $clog2(FRAMES);
  localparam int unsigned SLOT_W = $clog2(SLOTS);
  localparam int unsigned PAGE_W = 31;
  localparam int unsigned PIN_W  = 16;
  localparam int unsigned CNT_W  = 12;

  typedef enum logic [1:0] {
    CMD_FETCH = 2'd0,
    CMD_UNPIN = 2'd1,
    CMD_DIRTY = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ERR_OK     = 2'd0,
    ERR_ABSENT = 2'd1,
    ERR_PINNED = 2'd2
  } err_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_FIND,
    S_HIT,
    S_SWEEP,
    S_RFIND,
    S_SHIFT,
    S_INS
  } state_e;

  typedef struct packed {
    logic [1:0]        command;
    logic [PAGE_W-1:0] page_number;
  } req_t;

  typedef struct packed {
    logic [1:0]        error_code;
    logic              was_hit;
    logic [FRM_W-1:0]  frame_index;
    logic              load_needed;
    logic              evicted_valid;
    logic [PAGE_W-1:0] evicted_page;
    logic              writeback_needed;
  } res_t;

  typedef struct packed {
    logic              occ;
    logic [PAGE_W-1:0] page;
    logic [FRM_W-1:0]  frame;
  } slot_t;

  typedef struct packed {
    logic [PAGE_W-1:0] page;
    logic              dirty;
    logic [PIN_W-1:0]  pins;
    logic              refd;
  } frame_t;

endpackage

FILE: rtl/buffer_pool_frame_manager.sv
// A request probes the slot table from the page's home slot. A fetch hit, or an unpin or
// mark dirty of a resident page, then reads and updates its frame; an absent page or a miss
// into an unused frame is answered from the probe. An eviction adds the clock hand's visit
// of frames and the delete and insert probes of the slot table. The unknown command is
// answered without a probe. One request at a time, set by the single read port of each memory;
// the receiver cannot stall. Reset: async, active low; then a clearing pass over every slot and frame.
module buffer_pool_frame_manager import bpfm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  input  req_t req_i,
  output logic busy,
  output logic res_valid_o,
  output res_t res_o
);

  state_e state_q, state_d;
  cmd_e              cmd_q, cmd_d;
  logic [PAGE_W-1:0] page_q, page_d;
  logic [PAGE_W-1:0] vpage_q, vpage_d;
  logic              vdirty_q, vdirty_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [SLOT_W-1:0] gap_q, gap_d;
  logic [CNT_W-1:0]  n_q, n_d;
  logic [FRM_W-1:0]  frame_q, frame_d;
  logic [FRM_W-1:0]  sweep_q, sweep_d;
  logic [FRM_W:0]    unused_q, unused_d;
  res_t              res_q, res_d;
  logic              rv_q, rv_d;

  logic              s_we;
  logic [SLOT_W-1:0] s_waddr, s_raddr;
  slot_t             s_wdata, s_rd;
  logic              f_we;
  logic [FRM_W-1:0]  f_waddr, f_raddr;
  frame_t            f_wdata, f_rd;

  logic [SLOT_W-1:0] slot_nx, home, probe_dist, span;
  logic [FRM_W-1:0]  fr_new;
  logic              s_match, s_miss, occ_eff, victim;

  bpfm_ram #(.DEPTH(SLOTS), .WIDTH($bits(slot_t))) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (s_we),
    .waddr_i(s_waddr),
    .wdata_i(s_wdata),
    .raddr_i(s_raddr),
    .rdata_o(s_rd)
  );

  bpfm_ram #(.DEPTH(FRAMES), .WIDTH($bits(frame_t))) u_frame_ram (
    .clk_i  (clk_i),
    .we_i   (f_we),
    .waddr_i(f_waddr),
    .wdata_i(f_wdata),
    .raddr_i(f_raddr),
    .rdata_o(f_rd)
  );

  assign slot_nx    = slot_q + SLOT_W'(1);
  assign home       = page_q[SLOT_W-1:0];
  assign s_match    = s_rd.occ && (s_rd.page == page_q);
  assign s_miss     = !s_rd.occ || (!s_match && (n_q == CNT_W'(SLOTS - 1)));
  assign occ_eff    = s_rd.occ && (slot_q != gap_q);
  assign probe_dist = slot_q - s_rd.page[SLOT_W-1:0];
  assign span       = slot_q - gap_q;
  assign fr_new     = FRM_W'(unused_q - (FRM_W+1)'(1));
  assign victim     = (f_rd.pins == '0) && !f_rd.refd;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: if (n_q == CNT_W'(SLOTS - 1)) state_d = S_IDLE;
      S_IDLE: begin
        if (start && (cmd_e'(req_i.command) != CMD_NONE)) state_d = S_FIND;
      end
      S_FIND: begin
        if (s_miss) begin
          state_d = (cmd_q == CMD_FETCH && unused_q == '0) ? S_SWEEP : S_IDLE;
        end else if (s_match) begin
          state_d = S_HIT;
        end
      end
      S_HIT: state_d = S_IDLE;
      S_SWEEP: begin
        if (victim) state_d = S_RFIND;
        else if (n_q == CNT_W'(2 * FRAMES)) state_d = S_IDLE;
      end
      S_RFIND: begin
        if (s_rd.occ && s_rd.page == vpage_q) state_d = S_SHIFT;
        else if (!s_rd.occ) state_d = S_INS;
      end
      S_SHIFT: if (!occ_eff) state_d = S_INS;
      S_INS: if (!s_rd.occ) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    cmd_d    = cmd_q;
    page_d   = page_q;
    vpage_d  = vpage_q;
    vdirty_d = vdirty_q;
    slot_d   = slot_q;
    gap_d    = gap_q;
    n_d      = n_q;
    frame_d  = frame_q;
    sweep_d  = sweep_q;
    unused_d = unused_q;
    res_d    = res_q;
    rv_d     = 1'b0;
    s_we     = 1'b0;
    s_waddr  = slot_q;
    s_wdata  = '0;
    s_raddr  = slot_q;
    f_we     = 1'b0;
    f_waddr  = frame_q;
    f_wdata  = '0;
    f_raddr  = frame_q;
    case (state_q)
      S_CLEAR: begin
        s_we    = 1'b1;
        s_waddr = n_q[SLOT_W-1:0];
        f_we    = 1'b1;
        f_waddr = n_q[FRM_W-1:0];
        n_d     = n_q + CNT_W'(1);
      end
      S_IDLE: begin
        if (start) begin
          cmd_d   = cmd_e'(req_i.command);
          page_d  = req_i.page_number;
          slot_d  = req_i.page_number[SLOT_W-1:0];
          s_raddr = req_i.page_number[SLOT_W-1:0];
          n_d     = '0;
          if (cmd_e'(req_i.command) == CMD_NONE) begin
            rv_d  = 1'b1;
            res_d = '0;
          end
        end
      end
      S_FIND: begin
        if (s_miss) begin
          if (cmd_q != CMD_FETCH) begin
            rv_d             = 1'b1;
            res_d            = '0;
            res_d.error_code = ERR_ABSENT;
          end else if (unused_q != '0) begin
            rv_d  = 1'b1;
            res_d = '0;
            if (!s_rd.occ) begin
              s_we              = 1'b1;
              s_wdata           = '{occ: 1'b1, page: page_q, frame: fr_new};
              f_we              = 1'b1;
              f_waddr           = fr_new;
              f_wdata           = '{page: page_q, dirty: 1'b0, pins: PIN_W'(1), refd: 1'b1};
              unused_d          = unused_q - (FRM_W+1)'(1);
              res_d.frame_index = fr_new;
              res_d.load_needed = 1'b1;
            end else begin
              res_d.error_code = ERR_PINNED;
            end
          end else begin
            f_raddr = sweep_q;
            frame_d = sweep_q;
            n_d     = '0;
          end
        end else if (s_match) begin
          f_raddr = s_rd.frame;
          frame_d = s_rd.frame;
        end else begin
          slot_d  = slot_nx;
          s_raddr = slot_nx;
          n_d     = n_q + CNT_W'(1);
        end
      end
      S_HIT: begin
        f_we    = 1'b1;
        f_wdata = f_rd;
        res_d   = '0;
        case (cmd_q)
          CMD_FETCH: begin
            if (f_rd.pins != '1) f_wdata.pins = f_rd.pins + PIN_W'(1);
            f_wdata.refd  = 1'b1;
            res_d.was_hit = 1'b1;
          end
          CMD_UNPIN: if (f_rd.pins != '0) f_wdata.pins = f_rd.pins - PIN_W'(1);
          CMD_DIRTY: f_wdata.dirty = 1'b1;
          default: f_we = 1'b0;
        endcase
        rv_d              = 1'b1;
        res_d.frame_index = frame_q;
      end
      S_SWEEP: begin
        sweep_d = frame_q + FRM_W'(1);
        if (victim) begin
          vpage_d  = f_rd.page;
          vdirty_d = f_rd.dirty;
          slot_d   = f_rd.page[SLOT_W-1:0];
          s_raddr  = f_rd.page[SLOT_W-1:0];
        end else begin
          if (f_rd.pins == '0) begin
            f_we         = 1'b1;
            f_wdata      = f_rd;
            f_wdata.refd = 1'b0;
          end
          if (n_q == CNT_W'(2 * FRAMES)) begin
            rv_d             = 1'b1;
            res_d            = '0;
            res_d.error_code = ERR_PINNED;
          end else begin
            frame_d = frame_q + FRM_W'(1);
            f_raddr = frame_q + FRM_W'(1);
            n_d     = n_q + CNT_W'(1);
          end
        end
      end
      S_RFIND: begin
        if (s_rd.occ && s_rd.page == vpage_q) begin
          gap_d   = slot_q;
          slot_d  = slot_nx;
          s_raddr = slot_nx;
        end else if (!s_rd.occ) begin
          slot_d  = home;
          s_raddr = home;
        end else begin
          slot_d  = slot_nx;
          s_raddr = slot_nx;
        end
      end
      S_SHIFT: begin
        // backward shift; the gap slot is cleared once the run ends
        if (!occ_eff) begin
          s_we    = 1'b1;
          s_waddr = gap_q;
          slot_d  = home;
          s_raddr = home;
        end else begin
          if (probe_dist >= span) begin
            s_we    = 1'b1;
            s_waddr = gap_q;
            s_wdata = s_rd;
            gap_d   = slot_q;
          end
          slot_d  = slot_nx;
          s_raddr = slot_nx;
        end
      end
      S_INS: begin
        if (!s_rd.occ) begin
          s_we                   = 1'b1;
          s_wdata                = '{occ: 1'b1, page: page_q, frame: frame_q};
          f_we                   = 1'b1;
          f_wdata                = '{page: page_q, dirty: 1'b0, pins: PIN_W'(1), refd: 1'b1};
          rv_d                   = 1'b1;
          res_d                  = '0;
          res_d.frame_index      = frame_q;
          res_d.load_needed      = 1'b1;
          res_d.evicted_valid    = 1'b1;
          res_d.evicted_page     = vpage_q;
          res_d.writeback_needed = vdirty_q;
        end else begin
          slot_d  = slot_nx;
          s_raddr = slot_nx;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      n_q      <= '0;
      sweep_q  <= '0;
      unused_q <= (FRM_W+1)'(FRAMES);
      rv_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      n_q      <= n_d;
      sweep_q  <= sweep_d;
      unused_q <= unused_d;
      rv_q     <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    page_q   <= page_d;
    vpage_q  <= vpage_d;
    vdirty_q <= vdirty_d;
    slot_q   <= slot_d;
    gap_q    <= gap_d;
    frame_q  <= frame_d;
    res_q    <= res_d;
  end

  assign busy        = (state_q != S_IDLE);
  assign res_valid_o = rv_q;
  assign res_o       = res_q;

`ifndef SYNTHESIS
  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> !busy)
    else $error("result beat while a request is still in flight");

  a_error_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.error_code != ERR_OK) |->
      (!res_o.was_hit && !res_o.load_needed && !res_o.evicted_valid &&
       res_o.frame_index == '0))
    else $error("error beat carries payload");

  a_unused_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    unused_q <= (FRM_W+1)'(FRAMES))
    else $error("unused frame count out of range");

  a_evict_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.evicted_valid) |-> (unused_q == '0))
    else $error("eviction while unused frames remain");
`endif

endmodule

FILE: rtl/bpfm_ram.sv
module bpfm_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // write-first: a read of the entry being written returns the new data
  always_ff @(posedge clk_i) begin
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_o <= wdata_i;
    end else begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

FILE: bench/buffer_pool_frame_manager_tb.sv
`timescale 1ns / 100ps

module buffer_pool_frame_manager_tb;
  import bpfm_pkg::*;

  class pool_scoreboard;
    logic [PAGE_W-1:0] frame_page [FRAMES];
    bit                frame_dirty [FRAMES];
    int unsigned       frame_pins [FRAMES];
    bit                frame_refd [FRAMES];
    bit                slot_occ [SLOTS];
    logic [PAGE_W-1:0] slot_page [SLOTS];
    int unsigned       slot_frame [SLOTS];
    int unsigned       hand;
    int unsigned       unused;
    res_t              expected_q [$];
    int                errors;

    function new();
      for (int i = 0; i < FRAMES; i++) begin
        frame_dirty[i] = 0;
        frame_pins[i]  = 0;
        frame_refd[i]  = 0;
      end
      for (int i = 0; i < SLOTS; i++) slot_occ[i] = 0;
      hand   = 0;
      unused = FRAMES;
      errors = 0;
    endfunction

    function int find_slot(logic [PAGE_W-1:0] page);
      int unsigned s;
      s = page % SLOTS;
      for (int n = 0; n < SLOTS; n++) begin
        if (!slot_occ[s]) return -1;
        if (slot_page[s] == page) return s;
        s = (s + 1) % SLOTS;
      end
      return -1;
    endfunction

    function bit slot_insert(logic [PAGE_W-1:0] page, int unsigned frame);
      int unsigned s;
      s = page % SLOTS;
      for (int n = 0; n < SLOTS; n++) begin
        if (!slot_occ[s]) begin
          slot_occ[s]   = 1;
          slot_page[s]  = page;
          slot_frame[s] = frame;
          return 1;
        end
        s = (s + 1) % SLOTS;
      end
      return 0;
    endfunction

    // backward-shift delete keeps probe chains unbroken
    function void slot_remove(logic [PAGE_W-1:0] page);
      int found;
      int unsigned gap, j, probe_dist, span;
      found = find_slot(page);
      if (found < 0) return;
      gap = found;
      slot_occ[gap] = 0;
      j = gap;
      for (int n = 0; n < SLOTS; n++) begin
        j = (j + 1) % SLOTS;
        if (!slot_occ[j]) break;
        probe_dist = (j + SLOTS - (slot_page[j] % SLOTS)) % SLOTS;
        span = (j + SLOTS - gap) % SLOTS;
        if (probe_dist >= span) begin
          slot_page[gap]  = slot_page[j];
          slot_frame[gap] = slot_frame[j];
          slot_occ[gap]   = 1;
          slot_occ[j]     = 0;
          gap = j;
        end
      end
    endfunction

    function int clock_victim();
      int unsigned h;
      for (int n = 0; n < 2 * FRAMES + 1; n++) begin
        h = hand % FRAMES;
        hand = (h + 1) % FRAMES;
        if (frame_pins[h] == 0) begin
          if (frame_refd[h]) frame_refd[h] = 0;
          else return h;
        end
      end
      return -1;
    endfunction

    function void note_request(req_t r);
      res_t e;
      int s, v;
      int unsigned frame;
      e = '0;
      if (r.command == CMD_NONE) begin
        expected_q.push_back(e);
        return;
      end
      s = find_slot(r.page_number);
      if (r.command != CMD_FETCH) begin
        if (s < 0) begin
          e.error_code = ERR_ABSENT;
        end else begin
          frame = slot_frame[s];
          if (r.command == CMD_UNPIN) begin
            if (frame_pins[frame] > 0) frame_pins[frame]--;
          end else begin
            frame_dirty[frame] = 1;
          end
          e.frame_index = FRM_W'(frame);
        end
        expected_q.push_back(e);
        return;
      end
      if (s >= 0) begin
        frame = slot_frame[s];
        if (frame_pins[frame] < (1 << PIN_W) - 1) frame_pins[frame]++;
        frame_refd[frame] = 1;
        e.was_hit = 1;
        e.frame_index = FRM_W'(frame);
        expected_q.push_back(e);
        return;
      end
      if (unused > 0) begin
        frame = unused - 1;
        if (!slot_insert(r.page_number, frame)) begin
          e.error_code = ERR_PINNED;
          expected_q.push_back(e);
          return;
        end
        unused--;
      end else begin
        v = clock_victim();
        if (v < 0) begin
          e.error_code = ERR_PINNED;
          expected_q.push_back(e);
          return;
        end
        frame = v;
        e.evicted_valid = 1;
        e.evicted_page = frame_page[frame];
        e.writeback_needed = frame_dirty[frame];
        slot_remove(frame_page[frame]);
        void'(slot_insert(r.page_number, frame));
      end
      frame_page[frame]  = r.page_number;
      frame_dirty[frame] = 0;
      frame_pins[frame]  = 1;
      frame_refd[frame]  = 1;
      e.frame_index = FRM_W'(frame);
      e.load_needed = 1;
      expected_q.push_back(e);
    endfunction

    function void check_result(res_t got);
      res_t e;
      if (expected_q.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (got.error_code !== e.error_code) begin
        $error("error_code exp %0d got %0d", e.error_code, got.error_code); errors++;
      end
      if (got.was_hit !== e.was_hit) begin
        $error("was_hit exp %0d got %0d", e.was_hit, got.was_hit); errors++;
      end
      if (got.frame_index !== e.frame_index) begin
        $error("frame_index exp %0d got %0d", e.frame_index, got.frame_index); errors++;
      end
      if (got.load_needed !== e.load_needed) begin
        $error("load_needed exp %0d got %0d", e.load_needed, got.load_needed); errors++;
      end
      if (got.evicted_valid !== e.evicted_valid) begin
        $error("evicted_valid exp %0d got %0d", e.evicted_valid, got.evicted_valid);
        errors++;
      end
      if (got.evicted_page !== e.evicted_page) begin
        $error("evicted_page exp %0h got %0h", e.evicted_page, got.evicted_page); errors++;
      end
      if (got.writeback_needed !== e.writeback_needed) begin
        $error("writeback_needed exp %0d got %0d", e.writeback_needed,
               got.writeback_needed);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic start;
  req_t req_i;
  logic busy;
  logic res_valid_o;
  res_t res_o;

  pool_scoreboard    pool_sb;
  int                idle_pct;
  logic [PAGE_W-1:0] page_set [1600];

  buffer_pool_frame_manager u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .req_i      (req_i),
    .busy       (busy),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) pool_sb.check_result(res_o);
  end

  // start stays high across back-to-back beats; it only drops for a gap
  task automatic send_req(input cmd_e cmd, input logic [PAGE_W-1:0] page);
    req_t r;
    r.command = cmd;
    r.page_number = page;
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    pool_sb.note_request(r);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (pool_sb.expected_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic random_req();
    int pick;
    cmd_e cmd;
    logic [PAGE_W-1:0] page;
    pick = $urandom_range(0, 99);
    if (pick < 50) cmd = CMD_FETCH;
    else if (pick < 80) cmd = CMD_UNPIN;
    else if (pick < 95) cmd = CMD_DIRTY;
    else cmd = CMD_NONE;
    if ($urandom_range(0, 9) == 0) page = PAGE_W'($urandom());
    else page = page_set[$urandom_range(0, 1599)];
    send_req(cmd, page);
  endtask

  initial begin
    pool_sb = new();
    rst_ni = 1'b0;
    start = 1'b0;
    req_i = '0;
    idle_pct = 0;
    for (int i = 0; i < 1600; i++) begin
      page_set[i] = PAGE_W'($urandom());
      page_set[i][10:0] = 11'(i % 1100);
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_req(CMD_UNPIN, 31'd5);
    send_req(CMD_DIRTY, 31'd5);
    send_req(CMD_NONE, 31'h7FFF_FFFF);
    send_req(CMD_FETCH, 31'd0);
    send_req(CMD_FETCH, 31'h7FFF_FFFF);
    send_req(CMD_FETCH, 31'd2048);
    send_req(CMD_FETCH, 31'd4096);
    send_req(CMD_FETCH, 31'd2048);
    send_req(CMD_DIRTY, 31'd2048);
    send_req(CMD_DIRTY, 31'h7FFF_FFFF);
    send_req(CMD_UNPIN, 31'd0);
    send_req(CMD_UNPIN, 31'd0);
    send_req(CMD_UNPIN, 31'd0);
    // repeated hits stack up pins on one frame
    for (int i = 0; i < 20; i++) send_req(CMD_FETCH, 31'd4096);

    // fill every frame; the tail evicts page 0 then hits an all-pinned pool
    idle_pct = 28;
    for (int i = 0; i < 1030; i++) send_req(CMD_FETCH, page_set[i]);
    drain();

    for (int i = 0; i < 520; i++) begin
      if (i == 175) idle_pct = 84;
      if (i == 350) idle_pct = 0;
      random_req();
    end
    drain();
    repeat (50) @(posedge clk_i);
    if (pool_sb.errors == 0) begin
      $display("buffer_pool_frame_manager verification clean");
    end else begin
      $display("buffer_pool_frame_manager verification failed");
    end
    $finish;
  end

  initial begin
    #1_000_000_000;
    $display("buffer_pool_frame_manager verification failed");
    $finish;
  end

endmodule

FILE: buffer_pool_frame_manager.f
rtl/bpfm_pkg.sv
rtl/bpfm_ram.sv
rtl/buffer_pool_frame_manager.sv
bench/buffer_pool_frame_manager_tb.sv
